[hw/rtl/tts_pkg.sv]
// Package: shared types and constants of the tick task scheduler.
package tts_pkg;
  localparam int MaxTasks = 32;
  localparam int TimeBits = 16;
  localparam int SlotBits = $clog2(MaxTasks);
  localparam int CountBits = $clog2(MaxTasks + 1);

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SRTF = 2'd1,
    POL_RR   = 2'd2,
    POL_RR3  = 2'd3
  } policy_e;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // Word passed from front to back through the queue.
  typedef struct packed {
    logic                cmd;
    logic [TimeBits-1:0] arrival;
    logic [TimeBits-1:0] service;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [TimeBits-1:0] tick_time;
    logic                idle;
    logic [4:0]          slot_index;
    logic [TimeBits-1:0] remaining_left;
    logic                task_done;
    logic [TimeBits-1:0] finish_time;
    logic [TimeBits-1:0] turnaround;
    logic [TimeBits-1:0] wait_ticks;
    logic                all_done;
    logic                add_rejected;
  } result_t;
endpackage

[hw/rtl/tick_task_scheduler.sv]
// Top level of the tick task scheduler.
// An add goes from the queue straight to the output state; a tick passes through
// the serial slot scan, which reads one table slot per cycle from the task memories,
// and then through the execute state and the output state.
// The back handles one word at a time; the front queue holds two more.
// Reset (rst_ni low, asynchronous) empties the table, clears time and counts;
// table memories are not cleared, only slots below the task count are read.
module tick_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] service_time_i,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] tick_time_o,
  output logic        idle_o,
  output logic [4:0]  slot_index_o,
  output logic [15:0] remaining_left_o,
  output logic        task_done_o,
  output logic [15:0] finish_time_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] wait_ticks_o,
  output logic        all_done_o,
  output logic        add_rejected_o
);
  import tts_pkg::*;

  logic       policy_q;
  logic [1:0] pol_q;
  item_t      push_data, pop_data;
  logic       push, full, pop, empty, busy;
  result_t    res;

  // Policy register; the user must write it only while idle (the block does not enforce it), so it is always open.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q    <= 2'd0;
      policy_q <= 1'b0;
    end else if (cfg_valid) begin
      pol_q    <= cfg_data_i;
      policy_q <= busy;
    end
  end

  tts_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .command_i, .arrival_time_i,
    .service_time_i, .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  tts_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(pop_data)
  );

  tts_back u_back (
    .clk_i, .rst_ni, .policy_i(pol_q), .empty_i(empty), .item_i(pop_data),
    .pop_o(pop), .out_valid, .out_ready, .res_o(res), .busy_o(busy)
  );

  assign tick_time_o       = res.tick_time;
  assign idle_o            = res.idle;
  assign slot_index_o      = res.slot_index;
  assign remaining_left_o  = res.remaining_left;
  assign task_done_o       = res.task_done;
  assign finish_time_o     = res.finish_time;
  assign turnaround_o      = res.turnaround;
  assign wait_ticks_o      = res.wait_ticks;
  assign all_done_o        = res.all_done;
  assign add_rejected_o    = res.add_rejected;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cfg_valid && busy))
    else $error("policy written while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !policy_q)
    else $error("policy write landed during work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (!(task_done_o && idle_o)))
    else $error("idle tick reports a finished task");
endmodule

[hw/rtl/tts_queue.sv]
// Two-entry queue between the front and the back.
module tts_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tts_pkg::item_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tts_pkg::item_t pop_data_o
);
  import tts_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
endmodule

[hw/rtl/tts_front.sv]
// Front: accepts input words, saturates times and passes the command on.
module tts_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command_i,
  input  logic [15:0]                  arrival_time_i,
  input  logic [15:0]                  service_time_i,
  output logic                         push_o,
  output tts_pkg::item_t               push_data_o,
  input  logic                         full_i
);
  import tts_pkg::*;

  function automatic logic [TimeBits-1:0] sat16(input logic [15:0] v);
    logic [TimeBits-1:0] r;
    if (TimeBits >= 16) r = TimeBits'(v);
    else if ((v >> TimeBits) != '0) r = '1;
    else r = TimeBits'(v);
    return r;
  endfunction

  assign in_ready = !full_i;
  assign push_o   = in_valid && !full_i;

  always_comb begin
    push_data_o.cmd     = command_i;
    push_data_o.arrival = sat16(arrival_time_i);
    push_data_o.service = sat16(service_time_i);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> in_ready)
    else $error("push without ready");
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_i |-> !push_o)
    else $error("push while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (in_valid && !full_i) |-> push_o)
    else $error("accepted word lost");
endmodule

[hw/rtl/tts_back.sv]
// Back: task table, serial slot scan and result register.
module tts_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             policy_i,
  input  logic                   empty_i,
  input  tts_pkg::item_t         item_i,
  output logic                   pop_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tts_pkg::result_t       res_o,
  output logic                   busy_o
);
  import tts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  localparam logic [TimeBits-1:0] TMax = '1;

  logic [TimeBits-1:0] arr_mem [MaxTasks];
  logic [TimeBits-1:0] svc_mem [MaxTasks];
  logic [TimeBits-1:0] rem_mem [MaxTasks];

  state_e               state_q, state_d;
  logic [CountBits-1:0] task_cnt_q, fin_cnt_q;
  logic [TimeBits-1:0]  now_q;
  logic [SlotBits-1:0]  fifo_ptr_q, last_q;
  logic [CountBits-1:0] k_q;          // scan step count
  logic [SlotBits-1:0]  s_q;          // slot being read
  logic                 found_q;
  logic [SlotBits-1:0]  best_q;
  logic [TimeBits-1:0]  best_rem_q;
  logic [TimeBits-1:0]  rd_arr_q, rd_svc_q, rd_rem_q;
  logic                 rd_vld_q;
  logic [SlotBits-1:0]  rd_slot_q;
  logic [TimeBits-1:0]  b_arr_q, b_svc_q;
  logic                 fifo_stop_q;
  result_t              res_q;
  result_t              res_pop;

  assign res_o     = res_q;
  assign out_valid = state_q == ST_OUT;
  assign busy_o    = state_q != ST_IDLE;
  assign pop_o     = state_q == ST_IDLE && !empty_i;

  logic [SlotBits-1:0] start_slot;
  always_comb begin
    start_slot = last_q + 1'b1;
    if ({1'b0, start_slot} >= task_cnt_q || last_q == SlotBits'(MaxTasks - 1)) start_slot = '0;
  end

  // Step slot index with wrap at task_count.
  logic [SlotBits-1:0] s_next;
  always_comb begin
    s_next = s_q + 1'b1;
    if ({1'b0, s_q} + 1'b1 >= task_cnt_q || s_q == SlotBits'(MaxTasks - 1)) s_next = '0;
  end

  // Evaluate the slot word read in the previous cycle.
  logic ready_rd;
  assign ready_rd = rd_rem_q != '0 && rd_arr_q <= now_q;

  logic [TimeBits:0]   comp_w;
  logic [TimeBits-1:0] comp, turn, waitv, rem_dec;
  always_comb begin
    comp_w  = {1'b0, now_q} + 1'b1;
    comp    = comp_w[TimeBits] ? TMax : comp_w[TimeBits-1:0];
    turn    = comp - b_arr_q;
    waitv   = turn >= b_svc_q ? turn - b_svc_q : '0;
    rem_dec = best_rem_q - 1'b1;
  end

  // Result of a popped word: complete for an add, time only for a tick.
  always_comb begin
    res_pop = '0;
    res_pop.tick_time = 16'(now_q);
    if (item_i.cmd == CMD_ADD) begin
      if (task_cnt_q >= CountBits'(MaxTasks)) begin
        res_pop.add_rejected = 1'b1;
        res_pop.all_done = fin_cnt_q == task_cnt_q;
      end else begin
        res_pop.slot_index = 5'(task_cnt_q);
        res_pop.all_done = item_i.service == '0 && fin_cnt_q == task_cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_arr_q <= arr_mem[s_q];
    rd_svc_q <= svc_mem[s_q];
    rd_rem_q <= rem_mem[s_q];
    rd_slot_q <= s_q;
    if (state_q == ST_IDLE && pop_o && item_i.cmd == CMD_ADD &&
        task_cnt_q < CountBits'(MaxTasks)) begin
      arr_mem[task_cnt_q[SlotBits-1:0]] <= item_i.arrival;
      svc_mem[task_cnt_q[SlotBits-1:0]] <= item_i.service;
      rem_mem[task_cnt_q[SlotBits-1:0]] <= item_i.service;
    end else if (state_q == ST_EXEC && found_q) begin
      rem_mem[best_q] <= rem_dec;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pop_o) state_d = item_i.cmd == CMD_ADD ? ST_OUT : ST_SCAN;
      ST_SCAN: if (rd_vld_q && (k_q == '0 ||
                   (policy_i == POL_FCFS && fifo_stop_q) ||
                   (policy_i[1] && found_q))) state_d = ST_EXEC;
               else if (!rd_vld_q && k_q == '0) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_OUT;
      ST_OUT:  if (out_ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // fifo_stop_q: FCFS scan already decided; k_q counts slots still to read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      task_cnt_q <= '0;
      fin_cnt_q  <= '0;
      now_q      <= '0;
      fifo_ptr_q <= '0;
      last_q     <= SlotBits'(MaxTasks - 1);
      k_q        <= '0;
      s_q        <= '0;
      found_q    <= 1'b0;
      best_q     <= '0;
      best_rem_q <= '0;
      rd_vld_q   <= 1'b0;
      fifo_stop_q <= 1'b0;
      b_arr_q    <= '0;
      b_svc_q    <= '0;
      res_q      <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            res_q <= res_pop;
            found_q <= 1'b0;
            fifo_stop_q <= 1'b0;
            rd_vld_q <= 1'b0;
            if (item_i.cmd == CMD_ADD) begin
              if (task_cnt_q < CountBits'(MaxTasks)) begin
                task_cnt_q <= task_cnt_q + 1'b1;
                if (item_i.service == '0) fin_cnt_q <= fin_cnt_q + 1'b1;
              end
            end else begin
              k_q <= (policy_i != POL_FCFS) ? task_cnt_q :
                     ({1'b0, fifo_ptr_q} >= task_cnt_q) ? '0 :
                     task_cnt_q - {1'b0, fifo_ptr_q};
              s_q <= (policy_i == POL_FCFS) ? fifo_ptr_q :
                     (policy_i == POL_SRTF) ? '0 : start_slot;
            end
          end
        end
        ST_SCAN: begin
          if (k_q != '0 && !fifo_stop_q && !(policy_i[1] && found_q && rd_vld_q)) begin
            rd_vld_q <= 1'b1;
            k_q      <= k_q - 1'b1;
            s_q      <= s_next;
          end else begin
            rd_vld_q <= 1'b0;
          end
          if (rd_vld_q && !fifo_stop_q && !(policy_i[1] && found_q)) begin
            priority if (policy_i == POL_FCFS) begin
              if (rd_rem_q != '0) begin
                fifo_stop_q <= 1'b1;
                fifo_ptr_q  <= rd_slot_q;
                found_q     <= rd_arr_q <= now_q;
                best_q <= rd_slot_q; best_rem_q <= rd_rem_q;
                b_arr_q <= rd_arr_q; b_svc_q <= rd_svc_q;
              end else if (k_q == '0) begin
                fifo_ptr_q <= SlotBits'(task_cnt_q);
              end
            end else if (ready_rd && (policy_i[1] || !found_q || rd_rem_q < best_rem_q)) begin
              found_q <= 1'b1;
              best_q <= rd_slot_q; best_rem_q <= rd_rem_q;
              b_arr_q <= rd_arr_q; b_svc_q <= rd_svc_q;
            end
          end
        end
        ST_EXEC: begin
          now_q <= comp;
          if (found_q) begin
            last_q <= best_q;
            res_q.slot_index <= 5'(best_q);
            res_q.remaining_left <= 16'(best_rem_q);
            if (rem_dec == '0) begin
              res_q.task_done <= 1'b1;
              res_q.finish_time <= 16'(comp);
              res_q.turnaround <= 16'(turn);
              res_q.wait_ticks <= 16'(waitv);
              fin_cnt_q <= fin_cnt_q + 1'b1;
              res_q.all_done <= fin_cnt_q + 1'b1 == task_cnt_q;
            end else begin
              res_q.all_done <= fin_cnt_q == task_cnt_q;
            end
          end else begin
            res_q.idle <= 1'b1;
            res_q.all_done <= fin_cnt_q == task_cnt_q;
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) fin_cnt_q <= task_cnt_q)
    else $error("finished count above task count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_q)))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && !found_q) |=> res_q.idle)
    else $error("idle tick not flagged");
endmodule
